FILE: hw/rtl/ierc_pkg.sv
package ierc_pkg;

    // Number of interrupt sources held in the enable and request registers (1 to 16)
    localparam int NUM_SOURCES = 14;

    localparam logic [15:0] SRC_MASK = 16'((32'd1 << NUM_SOURCES) - 32'd1);

    // Commands (s_tuser)
    localparam logic [1:0] CMD_RAISE = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Access sizes
    localparam logic [1:0] SIZE_BYTE    = 2'd0;
    localparam logic [1:0] SIZE_HALF    = 2'd1;
    localparam logic [1:0] SIZE_WORD    = 2'd2;
    localparam logic [1:0] SIZE_INVALID = 2'd3;

    // Result status (m_tuser)
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_IRQ  = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

    // Byte addresses in the register window, one bit wider than the offset
    // so that an overhanging access does not wrap
    localparam logic [4:0] ADDR_ENABLE_LO  = 5'd0;
    localparam logic [4:0] ADDR_ENABLE_HI  = 5'd1;
    localparam logic [4:0] ADDR_REQUEST_LO = 5'd2;
    localparam logic [4:0] ADDR_REQUEST_HI = 5'd3;
    localparam logic [4:0] ADDR_MASTER     = 5'd8;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  irq_number;
        logic [3:0]  access_offset;
        logic [1:0]  access_size;
        logic [31:0] write_data;
        logic        cpu_irq_disable;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        exception_raised;
        logic [3:0]  exception_source;
        logic [1:0]  status;
    } out_item_t;

endpackage

FILE: hw/rtl/interrupt_enable_request_controller.sv
// Interrupt enable/request controller with a little-endian register window:
// bytes 0-1 enable, bytes 2-3 request (write one to clear), byte 8 bit 0 master enable,
// all other bytes read zero and ignore writes. Each item is a raise, a bus write, a bus
// read or a no-op, and gives exactly one result. An item is held in the input
// register, is executed against the registers as it moves to the result register, and
// is offered on the m_ side from there: one item per cycle sustained while m_tready is
// high. The rate is set by the combinational read-modify-write of the registers; the
// result and input registers stall together while a result waits with m_tready low.
module interrupt_enable_request_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] irq_number, [7:4] access_offset, [9:8] access_size,
    // [41:10] write_data, [42] cpu_irq_disable, [47:43] zero
    input  logic [ierc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] command
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] read_data, [32] exception_raised, [36:33] exception_source, [39:37] zero
    output logic [ierc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [1:0]                          m_tuser
);
    import ierc_pkg::*;

    logic                   in_vld_reg;
    in_item_t               in_item_reg;
    logic                   out_vld_reg;
    out_item_t              out_item_reg;
    logic [NUM_SOURCES-1:0] enable_reg;
    logic [NUM_SOURCES-1:0] request_reg;
    logic                   master_reg;

    logic                   out_free;
    logic                   advance;
    out_item_t              out_item_next;
    logic [NUM_SOURCES-1:0] enable_next;
    logic [NUM_SOURCES-1:0] request_next;
    logic                   master_next;

    logic [15:0]            en_wide;
    logic [15:0]            req_wide;
    logic [15:0]            en_new;
    logic [15:0]            req_new;
    logic                   master_new;
    logic [3:0]             lanes_on;
    logic [4:0]             addr;
    logic [7:0]             wbyte;
    logic [7:0]             rbyte;
    logic                   irq_ok;

    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    always_comb begin
        en_wide    = 16'(enable_reg);
        req_wide   = 16'(request_reg);
        en_new     = en_wide;
        req_new    = req_wide;
        master_new = master_reg;
        out_item_next = '0;
        addr  = '0;
        wbyte = '0;
        rbyte = '0;
        irq_ok = ({1'b0, in_item_reg.irq_number} < 5'(NUM_SOURCES));

        case (in_item_reg.access_size)
            SIZE_BYTE: lanes_on = 4'b0001;
            SIZE_HALF: lanes_on = 4'b0011;
            SIZE_WORD: lanes_on = 4'b1111;
            default:   lanes_on = 4'b0000;
        endcase

        case (in_item_reg.command)
            CMD_RAISE: begin
                if (!irq_ok) begin
                    out_item_next.status = STATUS_BAD_IRQ;
                end else if (master_reg && !in_item_reg.cpu_irq_disable &&
                             en_wide[in_item_reg.irq_number] &&
                             !req_wide[in_item_reg.irq_number]) begin
                    req_new[in_item_reg.irq_number] = 1'b1;
                    out_item_next.exception_raised  = 1'b1;
                    out_item_next.exception_source  = in_item_reg.irq_number;
                end
            end
            CMD_WRITE, CMD_READ: begin
                if (in_item_reg.access_size == SIZE_INVALID) begin
                    out_item_next.status = STATUS_BAD_SIZE;
                end
                // each lane addresses its own byte; lanes never collide
                for (int i = 0; i < 4; i++) begin
                    addr  = 5'(in_item_reg.access_offset) + 5'(i);
                    wbyte = in_item_reg.write_data[8*i +: 8];
                    case (addr)
                        ADDR_ENABLE_LO:  rbyte = en_wide[7:0];
                        ADDR_ENABLE_HI:  rbyte = en_wide[15:8];
                        ADDR_REQUEST_LO: rbyte = req_wide[7:0];
                        ADDR_REQUEST_HI: rbyte = req_wide[15:8];
                        ADDR_MASTER:     rbyte = {7'd0, master_reg};
                        default:         rbyte = 8'd0;
                    endcase
                    if (lanes_on[i]) begin
                        if (in_item_reg.command == CMD_READ) begin
                            out_item_next.read_data[8*i +: 8] = rbyte;
                        end else begin
                            case (addr)
                                ADDR_ENABLE_LO:  en_new[7:0]   = wbyte;
                                ADDR_ENABLE_HI:  en_new[15:8]  = wbyte;
                                ADDR_REQUEST_LO: req_new[7:0]  = req_wide[7:0] & ~wbyte;
                                ADDR_REQUEST_HI: req_new[15:8] = req_wide[15:8] & ~wbyte;
                                ADDR_MASTER:     master_new    = wbyte[0];
                                default:         ;
                            endcase
                        end
                    end
                end
            end
            default: ;
        endcase

        // bits at or above NUM_SOURCES are never stored
        enable_next  = NUM_SOURCES'(en_new & SRC_MASK);
        request_next = NUM_SOURCES'(req_new & SRC_MASK);
        master_next  = master_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            enable_reg  <= '0;
            request_reg <= '0;
            master_reg  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
                enable_reg  <= enable_next;
                request_reg <= request_next;
                master_reg  <= master_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.command         <= s_tuser;
            in_item_reg.irq_number      <= s_tdata[3:0];
            in_item_reg.access_offset   <= s_tdata[7:4];
            in_item_reg.access_size     <= s_tdata[9:8];
            in_item_reg.write_data      <= s_tdata[41:10];
            in_item_reg.cpu_irq_disable <= s_tdata[42];
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'd0, out_item_reg.exception_source,
                       out_item_reg.exception_raised, out_item_reg.read_data};
    assign m_tuser  = out_item_reg.status;

    logic [15:0] req_view;
    assign req_view = 16'(request_reg);

    // a reported exception leaves its request bit pending
    a_exc_sets_request: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_item_next.exception_raised
        |=> req_view[out_item_reg.exception_source])
        else $error("exception reported without its request bit set");

    // an exception only ever comes with a good status and no read data
    a_exc_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_item_reg.exception_raised
        |-> out_item_reg.status == STATUS_OK && out_item_reg.read_data == 32'd0)
        else $error("exception result carries status or data");

    // a waiting item is neither dropped nor overwritten while the result side stalls
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !out_free |=> in_vld_reg && $stable(in_item_reg))
        else $error("queued item lost during stall");

endmodule
